// ===== design/tls_client_hello_sni_extract_assert.svh =====
// Assertion macros for the SNI extractor checker.
`ifndef TLS_CLIENT_HELLO_SNI_EXTRACT_ASSERT_SVH
`define TLS_CLIENT_HELLO_SNI_EXTRACT_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define TLSSNI_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("tlssni: same-cycle check failed");

// Next-cycle implication, disabled while reset is active.
`define TLSSNI_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("tlssni: next-cycle check failed");

`endif

// ===== design/tlssni_pkg.sv =====
`timescale 1ns / 1ps

package tlssni_pkg;

    typedef enum logic [4:0] {
        PH_HEADER,
        PH_SID_LEN,
        PH_SID_SKIP,
        PH_CIPH_LEN,
        PH_CIPH_SKIP,
        PH_COMP_LEN,
        PH_COMP_SKIP,
        PH_EXTS_LEN,
        PH_EXT_TYPE,
        PH_EXT_LEN_SNI,
        PH_EXT_LEN_OTHER,
        PH_EXT_SKIP,
        PH_LIST_LEN,
        PH_ENTRY_TYPE,
        PH_ENTRY_LEN_HOST,
        PH_ENTRY_LEN_OTHER,
        PH_ENTRY_SKIP,
        PH_NAME,
        PH_DONE
    } parse_phase_t;

    localparam logic KIND_NAME   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] name_byte;
        logic       found;
        logic       last;
    } result_t;

    localparam logic [7:0]  RECORD_TYPE_HANDSHAKE = 8'h16;
    localparam logic [7:0]  VERSION_MAJOR         = 8'h03;
    localparam logic [7:0]  HS_TYPE_CLIENT_HELLO  = 8'h01;
    localparam logic [23:0] EXT_TYPE_SERVER_NAME  = 24'h000000;
    localparam logic [7:0]  NAME_TYPE_HOST        = 8'h00;

    localparam int RANDOM_LENGTH     = 32;
    localparam int POS_RECORD_TYPE   = 0;
    localparam int POS_VERSION_MAJOR = 1;
    localparam int POS_RECORD_LEN_HI = 3;
    localparam int POS_RECORD_LEN_LO = 4;
    localparam int POS_HS_TYPE       = 5;
    localparam int POS_HS_LEN_HI     = 6;
    localparam int POS_HS_LEN_MID    = 7;
    localparam int POS_HS_LEN_LO     = 8;
    localparam int HEADER_LAST_POS   = 5 + 4 + 2 + RANDOM_LENGTH - 1;

    localparam int LEN_FIELD_BYTES = 2;
    localparam int EXT_HEAD_LEN    = 4;
    localparam int ENTRY_HEAD_LEN  = 3;
    localparam int MIN_SNI_EXT_LEN = 2;

endpackage

// ===== design/tls_client_hello_sni_extract.sv =====
`timescale 1ns / 1ps
// Results: the first result of a byte is registered and shown on the m_ ports in the cycle after its transfer.
// Throughput: one byte per cycle while the output is not stalled; a name byte that
// also ends the message gives two items, and s_ready stays low while the second waits.
// Reset: synchronous active-low aresetn clears the parse state and both output
// slots at once; no clearing pass.
module tls_client_hello_sni_extract #(
    parameter int POSITION_WIDTH = 25
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_end_of_message,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_item_kind,
    output logic [7:0] m_name_byte,
    output logic       m_found,
    output logic       m_last
);

    localparam int PW = POSITION_WIDTH;
    localparam int SW = ((PW > 24) ? PW : 24) + 2;
    localparam logic [PW-1:0] POS_MAX   = {PW{1'b1}};
    localparam logic [SW-1:0] POS_LIMIT = SW'(POS_MAX);

    tlssni_pkg::parse_phase_t phase_reg, phase_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [23:0]   acc_reg, acc_next;
    logic [15:0]   rem_reg, rem_next;
    logic [PW-1:0] exts_end_reg, exts_end_next;
    logic [PW-1:0] ext_end_reg, ext_end_next;
    logic [15:0]   name_rem_reg, name_rem_next;
    logic [PW-1:0] req_reg, req_next;
    logic          reached_reg, reached_next;
    logic          failed_reg, failed_next;

    logic [SW-1:0] next_pos;
    logic [23:0]   acc_shift;
    logic [23:0]   operand;
    logic [SW-1:0] sum;
    logic          demand_ok;
    logic [PW-1:0] req_upd;
    logic [15:0]   rem_dec;
    logic          rem_zero;
    logic [15:0]   name_rem_dec;
    logic          ext_head_stop;
    logic          exts_head_stop;
    logic          entry_head_stop;
    logic          saturated;

    tlssni_pkg::result_t res0, res1, name_res, status_res;
    logic          emit_name;
    logic          status_ok;
    logic          push0, push1;

    logic          out_valid_reg, spill_valid_reg;
    tlssni_pkg::result_t out_reg, spill_reg;
    logic          s_fire, m_pop;

    assign s_ready = !spill_valid_reg && (!out_valid_reg || m_ready);
    assign s_fire  = s_valid && s_ready;
    assign m_pop   = out_valid_reg && m_ready;

    assign next_pos  = SW'(pos_reg) + SW'(1);
    assign acc_shift = {acc_reg[15:0], s_data_byte};
    assign operand   = (phase_reg == tlssni_pkg::PH_SID_LEN ||
                        phase_reg == tlssni_pkg::PH_COMP_LEN) ? 24'(s_data_byte) : acc_shift;
    assign sum       = next_pos + SW'(operand);
    assign demand_ok = (sum <= POS_LIMIT);
    assign req_upd   = (sum > SW'(req_reg)) ? PW'(sum) : req_reg;
    assign rem_dec   = rem_reg - 16'(rem_reg != 16'd0);
    assign rem_zero  = (rem_dec == 16'd0);
    assign name_rem_dec = name_rem_reg - 16'(name_rem_reg != 16'd0);
    assign saturated = (pos_reg == POS_MAX);

    assign ext_head_stop   = (next_pos + SW'(tlssni_pkg::EXT_HEAD_LEN)) > SW'(exts_end_reg);
    assign exts_head_stop  = (next_pos + SW'(tlssni_pkg::EXT_HEAD_LEN)) > sum;
    assign entry_head_stop = (next_pos + SW'(tlssni_pkg::ENTRY_HEAD_LEN)) > SW'(ext_end_reg);

    always_comb begin
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        exts_end_next = exts_end_reg;
        ext_end_next  = ext_end_reg;
        name_rem_next = name_rem_reg;
        req_next      = req_reg;
        reached_next  = reached_reg;
        failed_next   = failed_reg;
        pos_next      = saturated ? pos_reg : PW'(next_pos);

        if (saturated && phase_reg != tlssni_pkg::PH_DONE) begin
            failed_next = 1'b1;
            phase_next  = tlssni_pkg::PH_DONE;
        end else begin
            unique case (phase_reg) inside
                tlssni_pkg::PH_HEADER: begin
                    if ((pos_reg == PW'(tlssni_pkg::POS_RECORD_TYPE) &&
                         s_data_byte != tlssni_pkg::RECORD_TYPE_HANDSHAKE) ||
                        (pos_reg == PW'(tlssni_pkg::POS_VERSION_MAJOR) &&
                         s_data_byte != tlssni_pkg::VERSION_MAJOR) ||
                        (pos_reg == PW'(tlssni_pkg::POS_HS_TYPE) &&
                         s_data_byte != tlssni_pkg::HS_TYPE_CLIENT_HELLO)) begin
                        failed_next = 1'b1;
                        phase_next  = tlssni_pkg::PH_DONE;
                    end else if (pos_reg == PW'(tlssni_pkg::POS_RECORD_LEN_HI) ||
                                 pos_reg == PW'(tlssni_pkg::POS_HS_LEN_HI)) begin
                        acc_next = 24'(s_data_byte);
                    end else if (pos_reg == PW'(tlssni_pkg::POS_RECORD_LEN_LO) ||
                                 pos_reg == PW'(tlssni_pkg::POS_HS_LEN_LO)) begin
                        acc_next = acc_shift;
                        if (!demand_ok) begin
                            failed_next = 1'b1;
                            phase_next  = tlssni_pkg::PH_DONE;
                        end else begin
                            req_next = req_upd;
                        end
                    end else if (pos_reg == PW'(tlssni_pkg::POS_HS_LEN_MID)) begin
                        acc_next = acc_shift;
                    end else if (pos_reg >= PW'(tlssni_pkg::HEADER_LAST_POS)) begin
                        phase_next = tlssni_pkg::PH_SID_LEN;
                    end
                end
                tlssni_pkg::PH_SID_LEN, tlssni_pkg::PH_COMP_LEN: begin
                    if (!demand_ok) begin
                        failed_next = 1'b1;
                        phase_next  = tlssni_pkg::PH_DONE;
                    end else begin
                        req_next = req_upd;
                        acc_next = '0;
                        if (s_data_byte == 8'd0) begin
                            rem_next   = 16'(tlssni_pkg::LEN_FIELD_BYTES);
                            phase_next = (phase_reg == tlssni_pkg::PH_SID_LEN) ?
                                         tlssni_pkg::PH_CIPH_LEN : tlssni_pkg::PH_EXTS_LEN;
                        end else begin
                            rem_next   = 16'(s_data_byte);
                            phase_next = (phase_reg == tlssni_pkg::PH_SID_LEN) ?
                                         tlssni_pkg::PH_SID_SKIP : tlssni_pkg::PH_COMP_SKIP;
                        end
                    end
                end
                tlssni_pkg::PH_SID_SKIP, tlssni_pkg::PH_COMP_SKIP: begin
                    rem_next = rem_dec;
                    if (rem_zero) begin
                        rem_next   = 16'(tlssni_pkg::LEN_FIELD_BYTES);
                        acc_next   = '0;
                        phase_next = (phase_reg == tlssni_pkg::PH_SID_SKIP) ?
                                     tlssni_pkg::PH_CIPH_LEN : tlssni_pkg::PH_EXTS_LEN;
                    end
                end
                tlssni_pkg::PH_CIPH_LEN: begin
                    acc_next = acc_shift;
                    rem_next = rem_dec;
                    if (rem_zero) begin
                        if (!demand_ok) begin
                            failed_next = 1'b1;
                            phase_next  = tlssni_pkg::PH_DONE;
                        end else begin
                            req_next = req_upd;
                            if (acc_shift == 24'd0) begin
                                phase_next = tlssni_pkg::PH_COMP_LEN;
                            end else begin
                                rem_next   = acc_shift[15:0];
                                acc_next   = '0;
                                phase_next = tlssni_pkg::PH_CIPH_SKIP;
                            end
                        end
                    end
                end
                tlssni_pkg::PH_CIPH_SKIP: begin
                    rem_next = rem_dec;
                    if (rem_zero) begin
                        phase_next = tlssni_pkg::PH_COMP_LEN;
                    end
                end
                tlssni_pkg::PH_EXTS_LEN: begin
                    acc_next = acc_shift;
                    rem_next = rem_dec;
                    if (rem_zero) begin
                        if (!demand_ok) begin
                            failed_next = 1'b1;
                            phase_next  = tlssni_pkg::PH_DONE;
                        end else begin
                            req_next      = req_upd;
                            exts_end_next = PW'(sum);
                            if (exts_head_stop) begin
                                phase_next = tlssni_pkg::PH_DONE;
                            end else begin
                                rem_next   = 16'(tlssni_pkg::LEN_FIELD_BYTES);
                                acc_next   = '0;
                                phase_next = tlssni_pkg::PH_EXT_TYPE;
                            end
                        end
                    end
                end
                tlssni_pkg::PH_EXT_TYPE: begin
                    acc_next = acc_shift;
                    rem_next = rem_dec;
                    if (rem_zero) begin
                        rem_next   = 16'(tlssni_pkg::LEN_FIELD_BYTES);
                        acc_next   = '0;
                        phase_next = (acc_shift == tlssni_pkg::EXT_TYPE_SERVER_NAME) ?
                                     tlssni_pkg::PH_EXT_LEN_SNI : tlssni_pkg::PH_EXT_LEN_OTHER;
                    end
                end
                tlssni_pkg::PH_EXT_LEN_SNI, tlssni_pkg::PH_EXT_LEN_OTHER: begin
                    acc_next = acc_shift;
                    rem_next = rem_dec;
                    if (rem_zero) begin
                        if (sum > SW'(exts_end_reg)) begin
                            failed_next = 1'b1;
                            phase_next  = tlssni_pkg::PH_DONE;
                        end else begin
                            ext_end_next = PW'(sum);
                            if (phase_reg == tlssni_pkg::PH_EXT_LEN_SNI) begin
                                if (acc_shift < 24'(tlssni_pkg::MIN_SNI_EXT_LEN)) begin
                                    failed_next = 1'b1;
                                    phase_next  = tlssni_pkg::PH_DONE;
                                end else begin
                                    rem_next   = 16'(tlssni_pkg::LEN_FIELD_BYTES);
                                    acc_next   = '0;
                                    phase_next = tlssni_pkg::PH_LIST_LEN;
                                end
                            end else if (acc_shift == 24'd0) begin
                                if (ext_head_stop) begin
                                    phase_next = tlssni_pkg::PH_DONE;
                                end else begin
                                    rem_next   = 16'(tlssni_pkg::LEN_FIELD_BYTES);
                                    acc_next   = '0;
                                    phase_next = tlssni_pkg::PH_EXT_TYPE;
                                end
                            end else begin
                                rem_next   = acc_shift[15:0];
                                acc_next   = '0;
                                phase_next = tlssni_pkg::PH_EXT_SKIP;
                            end
                        end
                    end
                end
                tlssni_pkg::PH_EXT_SKIP: begin
                    rem_next = rem_dec;
                    if (rem_zero) begin
                        if (ext_head_stop) begin
                            phase_next = tlssni_pkg::PH_DONE;
                        end else begin
                            rem_next   = 16'(tlssni_pkg::LEN_FIELD_BYTES);
                            acc_next   = '0;
                            phase_next = tlssni_pkg::PH_EXT_TYPE;
                        end
                    end
                end
                tlssni_pkg::PH_LIST_LEN: begin
                    acc_next = acc_shift;
                    rem_next = rem_dec;
                    if (rem_zero) begin
                        if (sum > SW'(ext_end_reg)) begin
                            failed_next = 1'b1;
                            phase_next  = tlssni_pkg::PH_DONE;
                        end else begin
                            phase_next = entry_head_stop ? tlssni_pkg::PH_DONE :
                                                           tlssni_pkg::PH_ENTRY_TYPE;
                        end
                    end
                end
                tlssni_pkg::PH_ENTRY_TYPE: begin
                    rem_next   = 16'(tlssni_pkg::LEN_FIELD_BYTES);
                    acc_next   = '0;
                    phase_next = (s_data_byte == tlssni_pkg::NAME_TYPE_HOST) ?
                                 tlssni_pkg::PH_ENTRY_LEN_HOST : tlssni_pkg::PH_ENTRY_LEN_OTHER;
                end
                tlssni_pkg::PH_ENTRY_LEN_HOST, tlssni_pkg::PH_ENTRY_LEN_OTHER: begin
                    acc_next = acc_shift;
                    rem_next = rem_dec;
                    if (rem_zero) begin
                        if (sum > SW'(ext_end_reg)) begin
                            failed_next = 1'b1;
                            phase_next  = tlssni_pkg::PH_DONE;
                        end else if (phase_reg == tlssni_pkg::PH_ENTRY_LEN_HOST) begin
                            reached_next  = 1'b1;
                            name_rem_next = acc_shift[15:0];
                            phase_next    = (acc_shift[15:0] == 16'd0) ?
                                            tlssni_pkg::PH_DONE : tlssni_pkg::PH_NAME;
                        end else if (acc_shift == 24'd0) begin
                            phase_next = entry_head_stop ? tlssni_pkg::PH_DONE :
                                                           tlssni_pkg::PH_ENTRY_TYPE;
                        end else begin
                            rem_next   = acc_shift[15:0];
                            acc_next   = '0;
                            phase_next = tlssni_pkg::PH_ENTRY_SKIP;
                        end
                    end
                end
                tlssni_pkg::PH_ENTRY_SKIP: begin
                    rem_next = rem_dec;
                    if (rem_zero) begin
                        phase_next = entry_head_stop ? tlssni_pkg::PH_DONE :
                                                       tlssni_pkg::PH_ENTRY_TYPE;
                    end
                end
                tlssni_pkg::PH_NAME: begin
                    name_rem_next = name_rem_dec;
                    if (name_rem_dec == 16'd0) begin
                        phase_next = tlssni_pkg::PH_DONE;
                    end
                end
                default: begin
                    phase_next = tlssni_pkg::PH_DONE;
                end
            endcase
        end
    end

    always_comb begin
        emit_name  = (phase_reg == tlssni_pkg::PH_NAME) && !saturated;
        status_ok  = reached_next && !failed_next && (name_rem_next == 16'd0) &&
                     (pos_next >= req_next);
        name_res   = '{item_kind: tlssni_pkg::KIND_NAME, name_byte: s_data_byte,
                       found: 1'b0, last: 1'b0};
        status_res = '{item_kind: tlssni_pkg::KIND_STATUS, name_byte: 8'h00,
                       found: status_ok, last: 1'b1};
        res0  = emit_name ? name_res : status_res;
        res1  = status_res;
        push0 = emit_name || s_end_of_message;
        push1 = emit_name && s_end_of_message;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (s_fire && s_end_of_message)) begin
            phase_reg    <= tlssni_pkg::PH_HEADER;
            pos_reg      <= '0;
            acc_reg      <= '0;
            rem_reg      <= '0;
            exts_end_reg <= '0;
            ext_end_reg  <= '0;
            name_rem_reg <= '0;
            req_reg      <= '0;
            reached_reg  <= 1'b0;
            failed_reg   <= 1'b0;
        end else if (s_fire) begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            acc_reg      <= acc_next;
            rem_reg      <= rem_next;
            exts_end_reg <= exts_end_next;
            ext_end_reg  <= ext_end_next;
            name_rem_reg <= name_rem_next;
            req_reg      <= req_next;
            reached_reg  <= reached_next;
            failed_reg   <= failed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg   <= 1'b0;
            spill_valid_reg <= 1'b0;
        end else if (s_fire) begin
            out_valid_reg   <= push0;
            spill_valid_reg <= push1;
        end else if (m_pop) begin
            out_valid_reg   <= spill_valid_reg;
            spill_valid_reg <= 1'b0;
        end
    end

    // hold payload until transfer; advance spill slot on pop
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            out_reg   <= res0;
            spill_reg <= res1;
        end else if (m_pop) begin
            out_reg   <= spill_reg;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_item_kind = out_reg.item_kind;
    assign m_name_byte = out_reg.name_byte;
    assign m_found     = out_reg.found;
    assign m_last      = out_reg.last;

endmodule

// ===== design/tlssni_checker.sv =====
`timescale 1ns / 1ps
`include "tls_client_hello_sni_extract_assert.svh"

module tlssni_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_end_of_message,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_item_kind,
    input logic [7:0] m_name_byte,
    input logic       m_found,
    input logic       m_last
);

    `TLSSNI_ASSERT_IMPLY(a_last_marks_status, aclk, aresetn, m_valid, m_last == (m_item_kind == tlssni_pkg::KIND_STATUS))
    `TLSSNI_ASSERT_IMPLY(a_name_not_found, aclk, aresetn, m_valid && (m_item_kind == tlssni_pkg::KIND_NAME), !m_found)
    `TLSSNI_ASSERT_NEXT(a_eom_gives_result, aclk, aresetn, s_valid && s_ready && s_end_of_message, m_valid)
    `TLSSNI_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item_kind) && $stable(m_name_byte) && $stable(m_found) && $stable(m_last))

endmodule

bind tls_client_hello_sni_extract tlssni_checker u_tlssni_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_end_of_message (s_end_of_message),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_item_kind      (m_item_kind),
    .m_name_byte      (m_name_byte),
    .m_found          (m_found),
    .m_last           (m_last)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int POS_W = 25;
    localparam longint unsigned POS_LIMIT = (64'd1 << POS_W) - 1;

    logic       aclk;
    logic       aresetn          = 1'b0;
    logic       s_valid          = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte      = 8'h00;
    logic       s_end_of_message = 1'b0;
    logic       m_valid;
    logic       m_ready          = 1'b0;
    logic       m_item_kind;
    logic [7:0] m_name_byte;
    logic       m_found;
    logic       m_last;

    tls_client_hello_sni_extract #(
        .POSITION_WIDTH(POS_W)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_message(s_end_of_message),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item_kind     (m_item_kind),
        .m_name_byte     (m_name_byte),
        .m_found         (m_found),
        .m_last          (m_last)
    );

    tlssni_pkg::parse_phase_t ph;
    logic [POS_W-1:0]  rx_count;
    logic [23:0]       len_acc;
    logic [POS_W-1:0]  field_left;
    logic [POS_W-1:0]  exts_end;
    logic [POS_W-1:0]  ext_end;
    logic [15:0]       host_left;
    logic [POS_W-1:0]  min_total;
    logic              host_seen;
    logic              parse_bad;

    tlssni_pkg::result_t sni_results_due[$];
    logic [7:0] hello_bytes[$];
    int         sni_len_at;
    bit         idle_on;
    int         mismatches;
    int         n_bytes;
    int         n_msgs;
    int         n_names;
    int         n_status;
    int         n_found;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void sni_clear();
        ph         = tlssni_pkg::PH_HEADER;
        rx_count   = '0;
        len_acc    = '0;
        field_left = '0;
        exts_end   = '0;
        ext_end    = '0;
        host_left  = '0;
        min_total  = '0;
        host_seen  = 1'b0;
        parse_bad  = 1'b0;
    endfunction

    function automatic void fail_parse();
        parse_bad = 1'b1;
        ph        = tlssni_pkg::PH_DONE;
    endfunction

    function automatic bit demand_len(longint unsigned len);
        if (len > POS_LIMIT) begin
            fail_parse();
            return 1'b0;
        end
        if (len > min_total)
            min_total = POS_W'(len);
        return 1'b1;
    endfunction

    function automatic void start_field(tlssni_pkg::parse_phase_t next_ph,
                                        longint unsigned count);
        ph         = next_ph;
        field_left = POS_W'(count);
        len_acc    = '0;
    endfunction

    function automatic bit skip_byte();
        if (field_left > 0)
            field_left--;
        return field_left == 0;
    endfunction

    function automatic bit length_byte(logic [7:0] b);
        len_acc = {len_acc[15:0], b};
        return skip_byte();
    endfunction

    function automatic void ext_head(longint unsigned nxt);
        if (nxt + tlssni_pkg::EXT_HEAD_LEN > exts_end)
            ph = tlssni_pkg::PH_DONE;
        else
            start_field(tlssni_pkg::PH_EXT_TYPE, tlssni_pkg::LEN_FIELD_BYTES);
    endfunction

    function automatic void entry_head(longint unsigned nxt);
        if (nxt + tlssni_pkg::ENTRY_HEAD_LEN > ext_end)
            ph = tlssni_pkg::PH_DONE;
        else
            ph = tlssni_pkg::PH_ENTRY_TYPE;
    endfunction

    function automatic void sni_predict(logic [7:0] b, logic eom);
        longint unsigned pos;
        longint unsigned nxt;
        longint unsigned x;
        tlssni_pkg::result_t r;
        pos = rx_count;
        nxt = pos + 1;
        if (pos >= POS_LIMIT && ph != tlssni_pkg::PH_DONE)
            fail_parse();
        case (ph)
            tlssni_pkg::PH_HEADER: begin
                if ((pos == tlssni_pkg::POS_RECORD_TYPE &&
                     b != tlssni_pkg::RECORD_TYPE_HANDSHAKE) ||
                    (pos == tlssni_pkg::POS_VERSION_MAJOR &&
                     b != tlssni_pkg::VERSION_MAJOR) ||
                    (pos == tlssni_pkg::POS_HS_TYPE &&
                     b != tlssni_pkg::HS_TYPE_CLIENT_HELLO)) begin
                    fail_parse();
                end else if (pos == tlssni_pkg::POS_RECORD_LEN_HI ||
                             pos == tlssni_pkg::POS_HS_LEN_HI) begin
                    len_acc = {16'h0000, b};
                end else if (pos == tlssni_pkg::POS_RECORD_LEN_LO) begin
                    len_acc = {len_acc[15:0], b};
                    void'(demand_len(5 + longint'(len_acc)));
                end else if (pos == tlssni_pkg::POS_HS_LEN_MID) begin
                    len_acc = {len_acc[15:0], b};
                end else if (pos == tlssni_pkg::POS_HS_LEN_LO) begin
                    len_acc = {len_acc[15:0], b};
                    void'(demand_len(9 + longint'(len_acc)));
                end else if (pos >= tlssni_pkg::HEADER_LAST_POS) begin
                    ph = tlssni_pkg::PH_SID_LEN;
                end
            end
            tlssni_pkg::PH_SID_LEN: begin
                if (demand_len(nxt + b)) begin
                    if (b == 8'h00)
                        start_field(tlssni_pkg::PH_CIPH_LEN, tlssni_pkg::LEN_FIELD_BYTES);
                    else
                        start_field(tlssni_pkg::PH_SID_SKIP, b);
                end
            end
            tlssni_pkg::PH_SID_SKIP: begin
                if (skip_byte())
                    start_field(tlssni_pkg::PH_CIPH_LEN, tlssni_pkg::LEN_FIELD_BYTES);
            end
            tlssni_pkg::PH_CIPH_LEN: begin
                if (length_byte(b) && demand_len(nxt + len_acc)) begin
                    if (len_acc == 0)
                        ph = tlssni_pkg::PH_COMP_LEN;
                    else
                        start_field(tlssni_pkg::PH_CIPH_SKIP, len_acc);
                end
            end
            tlssni_pkg::PH_CIPH_SKIP: begin
                if (skip_byte())
                    ph = tlssni_pkg::PH_COMP_LEN;
            end
            tlssni_pkg::PH_COMP_LEN: begin
                if (demand_len(nxt + b)) begin
                    if (b == 8'h00)
                        start_field(tlssni_pkg::PH_EXTS_LEN, tlssni_pkg::LEN_FIELD_BYTES);
                    else
                        start_field(tlssni_pkg::PH_COMP_SKIP, b);
                end
            end
            tlssni_pkg::PH_COMP_SKIP: begin
                if (skip_byte())
                    start_field(tlssni_pkg::PH_EXTS_LEN, tlssni_pkg::LEN_FIELD_BYTES);
            end
            tlssni_pkg::PH_EXTS_LEN: begin
                if (length_byte(b)) begin
                    x = nxt + len_acc;
                    if (demand_len(x)) begin
                        exts_end = POS_W'(x);
                        ext_head(nxt);
                    end
                end
            end
            tlssni_pkg::PH_EXT_TYPE: begin
                if (length_byte(b))
                    start_field(len_acc == tlssni_pkg::EXT_TYPE_SERVER_NAME ?
                                tlssni_pkg::PH_EXT_LEN_SNI : tlssni_pkg::PH_EXT_LEN_OTHER,
                                tlssni_pkg::LEN_FIELD_BYTES);
            end
            tlssni_pkg::PH_EXT_LEN_SNI, tlssni_pkg::PH_EXT_LEN_OTHER: begin
                if (length_byte(b)) begin
                    x = nxt + len_acc;
                    if (x > exts_end) begin
                        fail_parse();
                    end else begin
                        ext_end = POS_W'(x);
                        if (ph == tlssni_pkg::PH_EXT_LEN_SNI) begin
                            if (len_acc < tlssni_pkg::MIN_SNI_EXT_LEN)
                                fail_parse();
                            else
                                start_field(tlssni_pkg::PH_LIST_LEN,
                                            tlssni_pkg::LEN_FIELD_BYTES);
                        end else if (len_acc == 0) begin
                            ext_head(nxt);
                        end else begin
                            start_field(tlssni_pkg::PH_EXT_SKIP, len_acc);
                        end
                    end
                end
            end
            tlssni_pkg::PH_EXT_SKIP: begin
                if (skip_byte())
                    ext_head(nxt);
            end
            tlssni_pkg::PH_LIST_LEN: begin
                if (length_byte(b)) begin
                    if (nxt + len_acc > ext_end)
                        fail_parse();
                    else
                        entry_head(nxt);
                end
            end
            tlssni_pkg::PH_ENTRY_TYPE: begin
                start_field(b == tlssni_pkg::NAME_TYPE_HOST ?
                            tlssni_pkg::PH_ENTRY_LEN_HOST : tlssni_pkg::PH_ENTRY_LEN_OTHER,
                            tlssni_pkg::LEN_FIELD_BYTES);
            end
            tlssni_pkg::PH_ENTRY_LEN_HOST, tlssni_pkg::PH_ENTRY_LEN_OTHER: begin
                if (length_byte(b)) begin
                    if (nxt + len_acc > ext_end) begin
                        fail_parse();
                    end else if (ph == tlssni_pkg::PH_ENTRY_LEN_HOST) begin
                        host_seen = 1'b1;
                        host_left = len_acc[15:0];
                        ph        = (host_left == 0) ? tlssni_pkg::PH_DONE :
                                                       tlssni_pkg::PH_NAME;
                    end else if (len_acc == 0) begin
                        entry_head(nxt);
                    end else begin
                        start_field(tlssni_pkg::PH_ENTRY_SKIP, len_acc);
                    end
                end
            end
            tlssni_pkg::PH_ENTRY_SKIP: begin
                if (skip_byte())
                    entry_head(nxt);
            end
            tlssni_pkg::PH_NAME: begin
                r = '{item_kind: tlssni_pkg::KIND_NAME, name_byte: b, found: 1'b0,
                      last: 1'b0};
                sni_results_due.push_back(r);
                if (host_left > 0)
                    host_left--;
                if (host_left == 0)
                    ph = tlssni_pkg::PH_DONE;
            end
            default: ph = tlssni_pkg::PH_DONE;
        endcase
        if (rx_count < POS_LIMIT)
            rx_count++;
        if (eom) begin
            r = '{item_kind: tlssni_pkg::KIND_STATUS, name_byte: 8'h00, last: 1'b1,
                  found: host_seen && !parse_bad && host_left == 0 &&
                         rx_count >= min_total};
            sni_results_due.push_back(r);
            sni_clear();
        end
    endfunction

    function automatic void flag_mismatch(string what, tlssni_pkg::result_t want,
                                          tlssni_pkg::result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display({"%0t %s: expected kind=%0d byte=%02h found=%0d last=%0d,",
                      " got kind=%0d byte=%02h found=%0d last=%0d"},
                     $realtime, what, want.item_kind, want.name_byte, want.found,
                     want.last, got.item_kind, got.name_byte, got.found, got.last);
    endfunction

    always @(posedge aclk) begin
        tlssni_pkg::result_t got;
        tlssni_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_item_kind, m_name_byte, m_found, m_last};
            if (sni_results_due.size() == 0) begin
                flag_mismatch("transfer with nothing due", '0, got);
            end else begin
                want = sni_results_due.pop_front();
                if (got.item_kind !== want.item_kind || got.name_byte !== want.name_byte ||
                    got.found !== want.found || got.last !== want.last)
                    flag_mismatch("mismatch", want, got);
                if (want.item_kind == tlssni_pkg::KIND_STATUS) begin
                    n_status++;
                    if (want.found)
                        n_found++;
                end else begin
                    n_names++;
                end
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (idle_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    function automatic void push_rand();
        hello_bytes.push_back(8'($urandom));
    endfunction

    function automatic void put16(int idx, int val);
        hello_bytes[idx]     = 8'(val >> 8);
        hello_bytes[idx + 1] = 8'(val);
    endfunction

    function automatic void add_other_ext();
        int t;
        int n;
        t = $urandom_range(1, 65535);
        n = $urandom_range(0, 4);
        hello_bytes.push_back(8'(t >> 8));
        hello_bytes.push_back(8'(t));
        hello_bytes.push_back(8'h00);
        hello_bytes.push_back(8'(n));
        repeat (n) push_rand();
    endfunction

    // host_n < 0 leaves the server_name extension without a host entry
    function automatic void build_hello(int sid_n, int ciph_n, int comp_n, int ext_pre,
                                        int ent_pre, int host_n, bit has_sni, int ext_post);
        int exts_at;
        int n;
        hello_bytes = {};
        hello_bytes.push_back(tlssni_pkg::RECORD_TYPE_HANDSHAKE);
        hello_bytes.push_back(tlssni_pkg::VERSION_MAJOR);
        hello_bytes.push_back(8'($urandom_range(0, 4)));
        repeat (2) hello_bytes.push_back(8'h00);
        hello_bytes.push_back(tlssni_pkg::HS_TYPE_CLIENT_HELLO);
        repeat (3) hello_bytes.push_back(8'h00);
        repeat (2 + tlssni_pkg::RANDOM_LENGTH) push_rand();
        hello_bytes.push_back(8'(sid_n));
        repeat (sid_n) push_rand();
        hello_bytes.push_back(8'(ciph_n >> 8));
        hello_bytes.push_back(8'(ciph_n));
        repeat (ciph_n) push_rand();
        hello_bytes.push_back(8'(comp_n));
        repeat (comp_n) push_rand();
        exts_at = hello_bytes.size();
        repeat (tlssni_pkg::LEN_FIELD_BYTES) hello_bytes.push_back(8'h00);
        repeat (ext_pre) add_other_ext();
        if (has_sni) begin
            hello_bytes.push_back(tlssni_pkg::EXT_TYPE_SERVER_NAME[15:8]);
            hello_bytes.push_back(tlssni_pkg::EXT_TYPE_SERVER_NAME[7:0]);
            sni_len_at = hello_bytes.size();
            repeat (2 * tlssni_pkg::LEN_FIELD_BYTES) hello_bytes.push_back(8'h00);
            repeat (ent_pre) begin
                n = $urandom_range(0, 3);
                hello_bytes.push_back(8'($urandom_range(1, 255)));
                hello_bytes.push_back(8'h00);
                hello_bytes.push_back(8'(n));
                repeat (n) push_rand();
            end
            if (host_n >= 0) begin
                hello_bytes.push_back(tlssni_pkg::NAME_TYPE_HOST);
                hello_bytes.push_back(8'(host_n >> 8));
                hello_bytes.push_back(8'(host_n));
                repeat (host_n) push_rand();
            end
            put16(sni_len_at, hello_bytes.size() - sni_len_at - 2);
            put16(sni_len_at + 2, hello_bytes.size() - sni_len_at - 4);
        end
        repeat (ext_post) add_other_ext();
        put16(exts_at, hello_bytes.size() - exts_at - 2);
        put16(tlssni_pkg::POS_RECORD_LEN_HI, hello_bytes.size() - 5);
        put16(tlssni_pkg::POS_HS_LEN_MID, hello_bytes.size() - 9);
    endfunction

    function automatic void random_hello();
        int host_n;
        case ($urandom_range(0, 9))
            0: host_n = -1;
            1: host_n = 0;
            default: host_n = $urandom_range(1, 16);
        endcase
        build_hello($urandom_range(0, 7) == 0 ? 32 : $urandom_range(0, 4),
                    $urandom_range(0, 6), $urandom_range(0, 2), $urandom_range(0, 2),
                    $urandom_range(0, 1), host_n, $urandom_range(0, 7) != 0,
                    $urandom_range(0, 1));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eom);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_data_byte      <= b;
        s_end_of_message <= eom;
        do @(posedge aclk); while (!s_ready);
        sni_predict(b, eom);
        n_bytes++;
    endtask

    task automatic send_msg();
        foreach (hello_bytes[i])
            send_byte(hello_bytes[i], i == hello_bytes.size() - 1);
        n_msgs++;
    endtask

    task automatic test_valid_hello();
        build_hello(0, 2, 1, 0, 0, 6, 1'b1, 0);
        send_msg();
        build_hello(32, 4, 1, 1, 1, 3, 1'b1, 1);
        hello_bytes[hello_bytes.size() - 7] = 8'h00;
        hello_bytes[hello_bytes.size() - 6] = 8'hFF;
        send_msg();
    endtask

    task automatic test_empty_name();
        build_hello(1, 2, 1, 1, 0, 0, 1'b1, 0);
        send_msg();
    endtask

    task automatic test_bad_markers();
        int marks[3] = '{tlssni_pkg::POS_RECORD_TYPE, tlssni_pkg::POS_VERSION_MAJOR,
                         tlssni_pkg::POS_HS_TYPE};
        foreach (marks[i]) begin
            build_hello(0, 2, 1, 0, 0, 4, 1'b1, 0);
            hello_bytes[marks[i]] = ~hello_bytes[marks[i]];
            send_msg();
        end
    endtask

    task automatic test_short_message();
        build_hello(0, 2, 1, 0, 0, 8, 1'b1, 0);
        repeat (3) void'(hello_bytes.pop_back());
        send_msg();
        // record length claims more bytes than arrive: names go out, status shows not found
        build_hello(0, 2, 1, 0, 0, 5, 1'b1, 0);
        put16(tlssni_pkg::POS_RECORD_LEN_HI, hello_bytes.size());
        send_msg();
        build_hello(0, 2, 1, 0, 0, 5, 1'b1, 0);
        hello_bytes[tlssni_pkg::POS_HS_LEN_HI] = 8'hFF;
        send_msg();
        hello_bytes = {tlssni_pkg::RECORD_TYPE_HANDSHAKE};
        send_msg();
    endtask

    task automatic test_missing_name();
        build_hello(2, 2, 1, 2, 0, 5, 1'b0, 0);
        send_msg();
        build_hello(0, 2, 1, 0, 2, -1, 1'b1, 1);
        send_msg();
    endtask

    task automatic test_bad_lengths();
        build_hello(0, 2, 1, 0, 0, 4, 1'b1, 0);
        put16(sni_len_at, 1);
        send_msg();
        build_hello(0, 2, 1, 0, 0, 4, 1'b1, 0);
        put16(sni_len_at + 2, 200);
        send_msg();
        build_hello(0, 2, 1, 1, 0, 4, 1'b1, 0);
        put16(sni_len_at, 300);
        send_msg();
    endtask

    task automatic test_trailing_bytes();
        build_hello(0, 2, 1, 0, 0, 3, 1'b1, 0);
        hello_bytes.push_back(8'h00);
        hello_bytes.push_back(8'hFF);
        repeat (3) push_rand();
        send_msg();
    endtask

    task automatic test_random_messages();
        int start;
        int roll;
        start = n_bytes;
        while (n_bytes - start < 80) begin
            idle_on = ($urandom_range(0, 3) != 0);
            roll    = $urandom_range(0, 99);
            if (roll < 15) begin
                hello_bytes = {};
                repeat ($urandom_range(1, 12)) push_rand();
                if (roll < 8)
                    hello_bytes[0] = tlssni_pkg::RECORD_TYPE_HANDSHAKE;
            end else begin
                random_hello();
                if (roll < 40) begin
                    case ($urandom_range(0, 3))
                        0: hello_bytes[$urandom_range(0, hello_bytes.size() - 1)] =
                               8'($urandom);
                        1: repeat ($urandom_range(1, hello_bytes.size() - 1))
                            void'(hello_bytes.pop_back());
                        2: repeat ($urandom_range(1, 8)) push_rand();
                        default:
                            hello_bytes[$urandom_range(tlssni_pkg::HEADER_LAST_POS + 1,
                                                       hello_bytes.size() - 1)] =
                                8'($urandom);
                    endcase
                end
            end
            send_msg();
        end
    endtask

    task automatic test_steady_stream();
        int start;
        start   = n_bytes;
        idle_on = 1'b0;
        while (n_bytes - start < 40) begin
            random_hello();
            send_msg();
        end
    endtask

    initial begin
        sni_clear();
        idle_on = 1'b1;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_valid_hello();
        test_empty_name();
        test_bad_markers();
        test_short_message();
        test_missing_name();
        test_bad_lengths();
        test_trailing_bytes();
        test_random_messages();
        test_steady_stream();
        s_valid <= 1'b0;
        while (sni_results_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Sent %0d ClientHello-style messages, %0d bytes in all.", n_msgs, n_bytes);
        $display("Checked %0d host name bytes and %0d status items (%0d with a valid name).",
                 n_names, n_status, n_found);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== tls_client_hello_sni_extract.f =====
+incdir+design
design/tlssni_pkg.sv
design/tls_client_hello_sni_extract.sv
design/tlssni_checker.sv
test/tb.sv
